// ===== design/skct_pkg.sv =====
`default_nettype none

package skct_pkg;

   localparam int CAPACITY = 64;
   localparam int ID_WIDTH = 32;

   typedef enum logic [1:0] {
      CMD_LOOKUP        = 2'd0,
      CMD_LOOKUP_INSERT = 2'd1,
      CMD_UPDATE        = 2'd2,
      CMD_SET_INSERT    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_COPY_SET = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] key;
      logic [ID_WIDTH-1:0] copy;
      logic                copy_valid;
      logic                occupied;
   } entry_type;

   typedef struct packed {
      logic                cmp_en;
      logic                insert_en;
      logic                set_en;
      logic [ID_WIDTH-1:0] key;
      logic [ID_WIDTH-1:0] copy;
      logic                copy_valid;
   } ctl_type;

endpackage

`default_nettype wire

// ===== design/skct_if.sv =====
`default_nettype none

interface skct_req_if
   import skct_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [ID_WIDTH-1:0] key;
   logic [ID_WIDTH-1:0] copy_in;

   modport source (output valid, cmd, key, copy_in, input ready);
   modport sink   (input valid, cmd, key, copy_in, output ready);
endinterface

interface skct_rsp_if
   import skct_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic                key_found;
   logic                copy_hit;
   logic [ID_WIDTH-1:0] copy_out;

   modport source (output valid, status, key_found, copy_hit, copy_out, input ready);
   modport sink   (input valid, status, key_found, copy_hit, copy_out, output ready);
endinterface

`default_nettype wire

// ===== design/skct_cell.sv =====
`default_nettype none

module skct_cell
   import skct_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire ctl_type   ctl,
   input  wire entry_type prev_entry,
   input  wire logic      prev_lt,
   output entry_type      entry,
   output logic           lt,
   output logic           eq
);

   entry_type entry_ff, entry_in;
   logic      lt_ff, lt_in;
   logic      eq_ff, eq_in;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = entry_ff.occupied && (entry_ff.key < ctl.key);
         eq_in = entry_ff.occupied && (entry_ff.key == ctl.key);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en && !lt_ff) begin
         if (prev_lt) begin
            entry_in.key        = ctl.key;
            entry_in.copy       = ctl.copy;
            entry_in.copy_valid = ctl.copy_valid;
            entry_in.occupied   = 1'b1;
         end else begin
            // shift up from the lower neighbor
            entry_in = prev_entry;
         end
      end
      if (ctl.set_en && eq_ff) begin
         entry_in.copy       = ctl.copy;
         entry_in.copy_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.occupied <= 1'b0;
      end else begin
         entry_ff.occupied <= entry_in.occupied;
      end
      entry_ff.key        <= entry_in.key;
      entry_ff.copy       <= entry_in.copy;
      entry_ff.copy_valid <= entry_in.copy_valid;
      lt_ff               <= lt_in;
      eq_ff               <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

`default_nettype wire

// ===== design/sorted_key_copy_table.sv =====
// Sorted key/copy table.
// Keeps up to 64 unique 32-bit keys in ascending order in a row of cells,
// each key with a 32-bit copy value and a copy-valid mark.
// req_chan (sink): valid/ready with cmd, key, copy_in. A transaction is taken
// when valid and ready are both high; ready is high only while the block is
// idle. rsp_chan (source): valid/ready with status, key_found, copy_hit,
// copy_out; one response per request.
// Timing: every cell compares its key against the request in the cycle after
// acceptance; then, once the response register is free, the cells apply the
// command (insert shifts the upper entries one cell up, set writes the matching
// cell) and the response register loads. A new request is taken only after
// the update step of the last one, when the block is idle again.
// The response register holds while the receiver stalls; a new request can be
// accepted meanwhile, and its update step waits until the register frees.
// Reset (synchronous, active high) empties the table and drops any pending
// response.
`default_nettype none

module sorted_key_copy_table
   import skct_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   skct_req_if.sink   req_chan,
   skct_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_ACT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]          cmd_ff;
   logic [ID_WIDTH-1:0] key_ff;
   logic [ID_WIDTH-1:0] copy_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff;
   logic                key_found_ff;
   logic                copy_hit_ff;
   logic [ID_WIDTH-1:0] copy_out_ff;

   ctl_type             ctl;
   entry_type           entry_vec [CAPACITY];
   logic [CAPACITY-1:0] lt_vec, eq_vec, occ_vec, cv_vec;

   logic                found, hit_cv, full, act_go, need_insert, is_lookup;
   logic [ID_WIDTH-1:0] hit_copy;
   logic [1:0]          status_in;

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_chan.valid) state_in = S_CMP;
         S_CMP:  state_in = S_ACT;
         S_ACT:  if (act_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff  <= req_chan.cmd;
         key_ff  <= req_chan.key;
         copy_ff <= req_chan.copy_in;
      end
   end

   always_comb begin
      found    = |eq_vec;
      hit_cv   = |(eq_vec & cv_vec);
      hit_copy = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq_vec[i] && cv_vec[i]) hit_copy = hit_copy | entry_vec[i].copy;
      end
   end

   assign full        = occ_vec[CAPACITY-1];
   assign act_go      = (state_ff == S_ACT) && (!rsp_valid_ff || rsp_chan.ready);
   assign is_lookup   = (cmd_ff == CMD_LOOKUP) || (cmd_ff == CMD_LOOKUP_INSERT);
   assign need_insert = !found &&
                        ((cmd_ff == CMD_LOOKUP_INSERT) || (cmd_ff == CMD_SET_INSERT));

   always_comb begin
      ctl.cmp_en     = (state_ff == S_CMP);
      ctl.insert_en  = act_go && need_insert && !full;
      ctl.set_en     = act_go && found &&
                       ((cmd_ff == CMD_UPDATE) || ((cmd_ff == CMD_SET_INSERT) && !hit_cv));
      ctl.key        = key_ff;
      ctl.copy       = copy_ff;
      ctl.copy_valid = (cmd_ff == CMD_SET_INSERT);
   end

   always_comb begin
      status_in = STATUS_OK;
      if (need_insert && full) begin
         status_in = STATUS_FULL;
      end else if ((cmd_ff == CMD_SET_INSERT) && found && hit_cv) begin
         status_in = STATUS_COPY_SET;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type prev_entry;
      logic      prev_lt;

      if (g == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_lt    = 1'b1;
      end else begin : g_rest
         assign prev_entry = entry_vec[g-1];
         assign prev_lt    = lt_vec[g-1];
      end

      skct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .entry      (entry_vec[g]),
         .lt         (lt_vec[g]),
         .eq         (eq_vec[g])
      );

      assign occ_vec[g] = entry_vec[g].occupied;
      assign cv_vec[g]  = entry_vec[g].copy_valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (act_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (act_go) begin
         status_ff    <= status_in;
         key_found_ff <= found;
         copy_hit_ff  <= is_lookup && hit_cv;
         copy_out_ff  <= (is_lookup && hit_cv) ? hit_copy : '0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.key_found = key_found_ff;
   assign rsp_chan.copy_hit  = copy_hit_ff;
   assign rsp_chan.copy_out  = copy_out_ff;

   a_eq_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT) |-> $onehot0(eq_vec))
      else $error("more than one cell matches the key");

   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT) |-> (((lt_vec + 1'b1) & lt_vec) == '0))
      else $error("less-than marks are not a prefix");

   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (((occ_vec + 1'b1) & occ_vec) == '0))
      else $error("occupied cells are not a prefix");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert_en |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1))
      else $error("insert did not add exactly one entry");

   a_rsp_from_act: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_ACT))
      else $error("response raised outside the update step");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import skct_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 20;
   localparam int POOL_SIZE   = 96;
   localparam int PHASE_ITEMS = 360;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] key;
      logic [31:0] copy;
      int unsigned send_idle;
      int unsigned recv_stall;
      bit          drain;
   } table_request_type;

   typedef struct {
      status_type  status;
      logic        key_found;
      logic        copy_hit;
      logic [31:0] copy_out;
   } table_answer_type;

   logic clock = 1'b0;
   logic reset;

   skct_req_if req_chan ();
   skct_rsp_if rsp_chan ();

   sorted_key_copy_table u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the sorted table
   logic [31:0] table_key [CAPACITY];
   logic [31:0] table_copy [CAPACITY];
   bit          table_has_copy [CAPACITY];
   int          table_fill = 0;

   table_request_type pending_requests [$];
   table_answer_type  expected_answers [$];
   logic [31:0]       key_pool [POOL_SIZE];

   int unsigned recv_stall_pct = 0;
   int          answers_seen   = 0;
   int          item_total     = 0;
   int          idle_cycles    = 0;
   bit          failed         = 1'b0;
   logic        req_taken      = 1'b0;

   function automatic void open_slot(int pos, logic [31:0] key, logic [31:0] copy,
                                     bit has_copy);
      for (int i = table_fill; i > pos; i--) begin
         table_key[i]      = table_key[i-1];
         table_copy[i]     = table_copy[i-1];
         table_has_copy[i] = table_has_copy[i-1];
      end
      table_key[pos]      = key;
      table_copy[pos]     = copy;
      table_has_copy[pos] = has_copy;
      table_fill++;
   endfunction

   function automatic table_answer_type table_access(cmd_type cmd, logic [31:0] key,
                                                     logic [31:0] copy);
      table_answer_type ans;
      int               pos;
      bit               hit;
      ans.status    = STATUS_OK;
      ans.key_found = 1'b0;
      ans.copy_hit  = 1'b0;
      ans.copy_out  = '0;
      pos = 0;
      while (pos < table_fill && table_key[pos] < key)
         pos++;
      hit = (pos < table_fill) && (table_key[pos] == key);
      case (cmd)
         CMD_LOOKUP, CMD_LOOKUP_INSERT: begin
            if (hit) begin
               if (table_has_copy[pos]) begin
                  ans.copy_hit = 1'b1;
                  ans.copy_out = table_copy[pos];
               end
            end else if (cmd == CMD_LOOKUP_INSERT) begin
               if (table_fill >= CAPACITY)
                  ans.status = STATUS_FULL;
               else
                  open_slot(pos, key, '0, 1'b0);
            end
         end
         CMD_UPDATE: begin
            if (hit) begin
               table_copy[pos]     = copy;
               table_has_copy[pos] = 1'b1;
            end
         end
         default: begin
            if (hit) begin
               if (table_has_copy[pos]) begin
                  ans.status = STATUS_COPY_SET;
               end else begin
                  table_copy[pos]     = copy;
                  table_has_copy[pos] = 1'b1;
               end
            end else if (table_fill >= CAPACITY) begin
               ans.status = STATUS_FULL;
            end else begin
               open_slot(pos, key, copy, 1'b1);
            end
         end
      endcase
      ans.key_found = hit;
      return ans;
   endfunction

   function automatic void queue_request(cmd_type cmd, logic [31:0] key, logic [31:0] copy,
                                         int unsigned send_idle, int unsigned recv_stall,
                                         bit drain);
      table_request_type r;
      r.cmd        = cmd;
      r.key        = key;
      r.copy       = copy;
      r.send_idle  = send_idle;
      r.recv_stall = recv_stall;
      r.drain      = drain;
      pending_requests.push_back(r);
   endfunction

   function automatic logic [31:0] pick_key();
      if ($urandom_range(99) < 80)
         return key_pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_copy();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // driver: advance to the next transaction on the falling edge
   always @(negedge clock) begin
      table_request_type nxt;
      if (!reset) begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (!req_chan.valid || req_taken) begin
            if (pending_requests.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else begin
               nxt = pending_requests[0];
               if ((nxt.drain && expected_answers.size() != 0) ||
                   $urandom_range(99) < nxt.send_idle) begin
                  req_chan.valid <= 1'b0;
               end else begin
                  nxt = pending_requests.pop_front();
                  recv_stall_pct   = nxt.recv_stall;
                  req_chan.valid   <= 1'b1;
                  req_chan.cmd     <= nxt.cmd;
                  req_chan.key     <= nxt.key;
                  req_chan.copy_in <= nxt.copy;
               end
            end
         end
      end
   end

   // monitor: check responses, predict on accepted requests
   always @(posedge clock) begin
      table_answer_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  failed = 1'b1;
               end
               if (rsp_chan.key_found !== want.key_found) begin
                  $error("key_found: expected %0d, got %0d", want.key_found,
                         rsp_chan.key_found);
                  failed = 1'b1;
               end
               if (rsp_chan.copy_hit !== want.copy_hit) begin
                  $error("copy_hit: expected %0d, got %0d", want.copy_hit,
                         rsp_chan.copy_hit);
                  failed = 1'b1;
               end
               if (rsp_chan.copy_out !== want.copy_out) begin
                  $error("copy_out: expected %h, got %h", want.copy_out, rsp_chan.copy_out);
                  failed = 1'b1;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_answers.push_back(table_access(cmd_type'(req_chan.cmd), req_chan.key,
                                                    req_chan.copy_in));
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned send_pct [4];
      int unsigned recv_pct [4];
      cmd_type     cmd;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.cmd     = CMD_LOOKUP;
      req_chan.key     = '0;
      req_chan.copy_in = '0;
      rsp_chan.ready   = 1'b0;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      queue_request(CMD_LOOKUP,        32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_UPDATE,        32'h0000_0005, 32'h1111_1111, 0, 0, 0);
      queue_request(CMD_LOOKUP_INSERT, 32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_LOOKUP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      queue_request(CMD_LOOKUP_INSERT, 32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_LOOKUP,        32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_SET_INSERT,    32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 0);
      queue_request(CMD_LOOKUP,        32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_SET_INSERT,    32'h0000_0000, 32'h0000_0001, 0, 0, 0);
      queue_request(CMD_UPDATE,        32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_LOOKUP,        32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_SET_INSERT,    32'h8000_0000, 32'h1234_5678, 0, 0, 0);
      queue_request(CMD_LOOKUP_INSERT, 32'h7FFF_FFFF, 32'h5555_5555, 0, 0, 0);
      queue_request(CMD_LOOKUP,        32'h8000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_LOOKUP_INSERT, 32'h8000_0000, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_UPDATE,        32'hFFFF_FFFF, 32'hAAAA_AAAA, 0, 0, 0);
      queue_request(CMD_LOOKUP,        32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_SET_INSERT,    32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_LOOKUP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_LOOKUP,        32'hFFFF_FFFE, 32'h0000_0000, 0, 0, 0);
      queue_request(CMD_UPDATE,        32'h5555_5555, 32'hFFFF_FFFF, 0, 0, 0);

      send_pct = '{0, 74, 0, 23};
      recv_pct = '{0, 0, 74, 23};
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            cmd = cmd_type'($urandom_range(3));
            queue_request(cmd, pick_key(), pick_copy(), send_pct[p], recv_pct[p], i == 0);
         end
      end
      item_total = pending_requests.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (answers_seen == item_total);
      repeat (SETTLE) @(posedge clock);
      if (expected_answers.size() != 0) begin
         $error("%0d responses never arrived", expected_answers.size());
         failed = 1'b1;
      end
      if (!failed)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
